// ===== rtl/kt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kt_pkg;

  localparam int unsigned ENTRIES = 1024;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int KEY_W = 10;
  localparam int VAL_W = 32;
  localparam int SUM_W = 64;

  typedef enum logic [2:0] {
    OP_SET    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_COUNT  = 3'd3,
    OP_QUERY  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_CHECK,
    ST_SWAP,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } val_cmd_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } idx_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/kt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  bit [WIDTH-1:0] mem [DEPTH];
  bit [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/kt_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kt_seq (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [2:0]                         in_op,
  input  wire logic [kt_pkg::KEY_W-1:0]           in_key,
  input  wire logic signed [kt_pkg::VAL_W-1:0]    in_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [kt_pkg::CNT_W-1:0]                out_valid_count,
  output logic signed [kt_pkg::VAL_W-1:0]         out_query_value,
  output logic signed [kt_pkg::SUM_W-1:0]         out_running_total,
  output kt_pkg::val_cmd_t                        val_cmd,
  output kt_pkg::idx_cmd_t                        pos_cmd,
  output kt_pkg::idx_cmd_t                        list_cmd,
  input  wire logic [kt_pkg::VAL_W-1:0]           val_rdata,
  input  wire logic [kt_pkg::IDX_W-1:0]           pos_rdata,
  input  wire logic [kt_pkg::IDX_W-1:0]           list_rdata
);

  kt_pkg::state_t               state_r, state_nxt;
  logic [2:0]                   op_r, op_nxt;
  logic [kt_pkg::KEY_W-1:0]     key_r, key_nxt;
  logic [kt_pkg::VAL_W-1:0]     value_r, value_nxt;
  logic [kt_pkg::VAL_W-1:0]     qv_r, qv_nxt;
  logic [kt_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [kt_pkg::SUM_W-1:0]     total_r, total_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [kt_pkg::CNT_W-1:0]     out_count_r, out_count_nxt;
  logic [kt_pkg::VAL_W-1:0]     out_qv_r, out_qv_nxt;
  logic [kt_pkg::SUM_W-1:0]     out_total_r, out_total_nxt;
  logic                         in_range;
  logic                         hit;
  logic [kt_pkg::VAL_W-1:0]     qv_calc;

  // A key is present when its stored list position lies below the count and
  // the list entry at that position points back at the key.
  assign in_range = (32'(key_r) < kt_pkg::ENTRIES);
  assign hit = in_range && (kt_pkg::CNT_W'(pos_rdata) < count_r) &&
               (list_rdata == kt_pkg::IDX_W'(key_r));
  assign qv_calc = hit ? val_rdata : '1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kt_pkg::ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    value_r     <= value_nxt;
    qv_r        <= qv_nxt;
    out_count_r <= out_count_nxt;
    out_qv_r    <= out_qv_nxt;
    out_total_r <= out_total_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    value_nxt     = value_r;
    qv_nxt        = qv_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    out_qv_nxt    = out_qv_r;
    out_total_nxt = out_total_r;
    in_ready      = 1'b0;

    val_cmd.we     = 1'b0;
    val_cmd.waddr  = kt_pkg::IDX_W'(key_r);
    val_cmd.wdata  = value_r;
    val_cmd.raddr  = (state_r == kt_pkg::ST_IDLE) ? kt_pkg::IDX_W'(in_key)
                                                  : kt_pkg::IDX_W'(key_r);
    pos_cmd.we     = 1'b0;
    pos_cmd.waddr  = kt_pkg::IDX_W'(key_r);
    pos_cmd.wdata  = kt_pkg::IDX_W'(count_r);
    pos_cmd.raddr  = val_cmd.raddr;
    list_cmd.we    = 1'b0;
    list_cmd.waddr = kt_pkg::IDX_W'(count_r);
    list_cmd.wdata = kt_pkg::IDX_W'(key_r);
    list_cmd.raddr = (state_r == kt_pkg::ST_CHECK) ?
                     kt_pkg::IDX_W'(count_r - kt_pkg::CNT_W'(1)) : pos_rdata;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      kt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt    = in_op;
          key_nxt   = in_key;
          value_nxt = in_value;
          qv_nxt    = '0;
          state_nxt = kt_pkg::ST_LOOK;
        end
      end
      kt_pkg::ST_LOOK: begin
        state_nxt = kt_pkg::ST_CHECK;
      end
      kt_pkg::ST_CHECK: begin
        state_nxt = kt_pkg::ST_RESP;
        case (op_r)
          kt_pkg::OP_SET: begin
            if (in_range) begin
              val_cmd.we = 1'b1;
              if (!hit && (32'(count_r) < kt_pkg::ENTRIES)) begin
                pos_cmd.we  = 1'b1;
                list_cmd.we = 1'b1;
                count_nxt   = count_r + kt_pkg::CNT_W'(1);
              end
            end
          end
          kt_pkg::OP_REMOVE: begin
            if (hit) begin
              state_nxt = kt_pkg::ST_SWAP;
            end
          end
          kt_pkg::OP_CLEAR: begin
            count_nxt = '0;
          end
          kt_pkg::OP_COUNT: begin
            total_nxt = total_r + kt_pkg::SUM_W'(count_r);
          end
          kt_pkg::OP_QUERY: begin
            qv_nxt    = qv_calc;
            total_nxt = total_r + {{(kt_pkg::SUM_W - kt_pkg::VAL_W){qv_calc[kt_pkg::VAL_W-1]}},
                                   qv_calc};
          end
          default: begin
            qv_nxt = '0;
          end
        endcase
      end
      kt_pkg::ST_SWAP: begin
        // The last list entry moves into the slot of the removed key.
        list_cmd.we    = 1'b1;
        list_cmd.waddr = pos_rdata;
        list_cmd.wdata = list_rdata;
        pos_cmd.we     = 1'b1;
        pos_cmd.waddr  = list_rdata;
        pos_cmd.wdata  = pos_rdata;
        count_nxt      = count_r - kt_pkg::CNT_W'(1);
        state_nxt      = kt_pkg::ST_RESP;
      end
      kt_pkg::ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          out_qv_nxt    = qv_r;
          out_total_nxt = total_r;
          state_nxt     = kt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = kt_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_valid_count   = out_count_r;
  assign out_query_value   = out_qv_r;
  assign out_running_total = out_total_r;

endmodule

`default_nettype wire

// ===== rtl/keyed_table_with_clear_all_top.sv =====
// Each accepted transaction steps through the states LOOK, CHECK and RESP, with SWAP
// between CHECK and RESP for a remove of a present key; the result is registered.
// A new transaction is accepted only in IDLE, once the last result is issued; the LOOK
// and CHECK states cover the chained reads key to list position to list entry in RAMs
// with registered reads. Clear all only zeroes the count. Reset clears the count, the
// running total and the control state; the table memories need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module keyed_table_with_clear_all_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [2:0]                      in_op,
  input  wire logic [9:0]                      in_key,
  input  wire logic signed [31:0]              in_value,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [10:0]                          out_valid_count,
  output logic signed [31:0]                   out_query_value,
  output logic signed [63:0]                   out_running_total
);

  kt_pkg::val_cmd_t             val_cmd;
  kt_pkg::idx_cmd_t             pos_cmd;
  kt_pkg::idx_cmd_t             list_cmd;
  logic [kt_pkg::VAL_W-1:0]     val_rdata;
  logic [kt_pkg::IDX_W-1:0]     pos_rdata;
  logic [kt_pkg::IDX_W-1:0]     list_rdata;

  kt_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_key            (in_key),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_valid_count   (out_valid_count),
    .out_query_value   (out_query_value),
    .out_running_total (out_running_total),
    .val_cmd           (val_cmd),
    .pos_cmd           (pos_cmd),
    .list_cmd          (list_cmd),
    .val_rdata         (val_rdata),
    .pos_rdata         (pos_rdata),
    .list_rdata        (list_rdata)
  );

  kt_ram #(.WIDTH(kt_pkg::VAL_W), .DEPTH(kt_pkg::ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (val_cmd.we),
    .waddr (val_cmd.waddr),
    .wdata (val_cmd.wdata),
    .raddr (val_cmd.raddr),
    .rdata (val_rdata)
  );

  kt_ram #(.WIDTH(kt_pkg::IDX_W), .DEPTH(kt_pkg::ENTRIES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_cmd.we),
    .waddr (pos_cmd.waddr),
    .wdata (pos_cmd.wdata),
    .raddr (pos_cmd.raddr),
    .rdata (pos_rdata)
  );

  kt_ram #(.WIDTH(kt_pkg::IDX_W), .DEPTH(kt_pkg::ENTRIES)) u_list_ram (
    .clk   (clk),
    .we    (list_cmd.we),
    .waddr (list_cmd.waddr),
    .wdata (list_cmd.wdata),
    .raddr (list_cmd.raddr),
    .rdata (list_rdata)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_valid_count) <= kt_pkg::ENTRIES))
    else $error("Valid key count exceeds the table size.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("A transaction was accepted while the previous one was in flight.");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("A result appeared without a transaction being processed.");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 12;
  localparam int ITEMS_PER_PHASE = 162;
  localparam int DIR_MAX = 32;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [kt_pkg::CNT_W-1:0] valid_count;
    logic [kt_pkg::VAL_W-1:0] query_value;
    logic [kt_pkg::SUM_W-1:0] running_total;
  } table_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [2:0] in_op;
  logic [kt_pkg::KEY_W-1:0] in_key;
  logic [kt_pkg::VAL_W-1:0] in_value;
  logic out_valid;
  logic out_ready;
  logic [kt_pkg::CNT_W-1:0] out_valid_count;
  logic signed [kt_pkg::VAL_W-1:0] out_query_value;
  logic signed [kt_pkg::SUM_W-1:0] out_running_total;

  logic [kt_pkg::VAL_W-1:0] model_value [kt_pkg::ENTRIES];
  bit model_valid [kt_pkg::ENTRIES];
  logic [kt_pkg::CNT_W-1:0] model_count;
  logic [kt_pkg::SUM_W-1:0] model_sum;
  table_result_t pending_results [$];
  int error_count;
  int quiet_cycles;
  idle_mode_t idle_mode;

  logic [2:0] dir_op [DIR_MAX];
  logic [kt_pkg::KEY_W-1:0] dir_key [DIR_MAX];
  logic [kt_pkg::VAL_W-1:0] dir_val [DIR_MAX];
  bit dir_typed [DIR_MAX];
  table_result_t dir_want [DIR_MAX];
  int dir_rows;

  keyed_table_with_clear_all_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_key           (in_key),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_valid_count  (out_valid_count),
    .out_query_value  (out_query_value),
    .out_running_total(out_running_total)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic predict_table(input logic [2:0] op, input logic [kt_pkg::KEY_W-1:0] key,
                               input logic [kt_pkg::VAL_W-1:0] val,
                               output table_result_t res);
    logic [kt_pkg::VAL_W-1:0] qv;
    qv = '0;
    case (op)
      kt_pkg::OP_SET: begin
        model_value[key] = val;
        if (!model_valid[key] && model_count < kt_pkg::CNT_W'(kt_pkg::ENTRIES)) begin
          model_valid[key] = 1'b1;
          model_count = model_count + 1'b1;
        end
      end
      kt_pkg::OP_REMOVE: begin
        if (model_valid[key]) begin
          model_valid[key] = 1'b0;
          model_count = model_count - 1'b1;
        end
      end
      kt_pkg::OP_CLEAR: begin
        foreach (model_valid[i]) model_valid[i] = 1'b0;
        model_count = '0;
      end
      kt_pkg::OP_COUNT: begin
        model_sum = model_sum + kt_pkg::SUM_W'(model_count);
      end
      kt_pkg::OP_QUERY: begin
        qv = model_valid[key] ? model_value[key] : '1;
        model_sum = model_sum +
                    {{(kt_pkg::SUM_W - kt_pkg::VAL_W){qv[kt_pkg::VAL_W-1]}}, qv};
      end
      default: begin
      end
    endcase
    res.valid_count = model_count;
    res.query_value = qv;
    res.running_total = model_sum;
  endtask

  task automatic send_cmd(input logic [2:0] op, input logic [kt_pkg::KEY_W-1:0] key,
                          input logic [kt_pkg::VAL_W-1:0] val, input bit typed,
                          input table_result_t typed_res);
    int idle_pct;
    table_result_t predicted;
    idle_pct = (idle_mode == IDLE_SENDER) ? 45 : (idle_mode == IDLE_BOTH) ? 19 : 0;
    @(negedge clk);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_op = op;
    in_key = key;
    in_value = val;
    do @(posedge clk); while (!in_ready);
    predict_table(op, key, val, predicted);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic add_row(input logic [2:0] op, input logic [kt_pkg::KEY_W-1:0] key,
                         input logic [kt_pkg::VAL_W-1:0] val, input bit typed,
                         input logic [kt_pkg::CNT_W-1:0] cnt,
                         input logic [kt_pkg::VAL_W-1:0] qv,
                         input logic [kt_pkg::SUM_W-1:0] tot);
    dir_op[dir_rows] = op;
    dir_key[dir_rows] = key;
    dir_val[dir_rows] = val;
    dir_typed[dir_rows] = typed;
    dir_want[dir_rows].valid_count = cnt;
    dir_want[dir_rows].query_value = qv;
    dir_want[dir_rows].running_total = tot;
    dir_rows++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name,
               $signed(want), $signed(got));
      error_count++;
    end
  endtask

  always @(negedge clk) begin
    int stall_pct;
    stall_pct = (idle_mode == IDLE_RECEIVER) ? 45 : (idle_mode == IDLE_BOTH) ? 19 : 0;
    out_ready = ($urandom_range(99, 0) >= stall_pct);
  end

  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction: count %0d, value %0d, total %0d", $time,
                 out_valid_count, out_query_value, out_running_total);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("valid_count", 64'(want.valid_count), 64'(out_valid_count));
        check_field("query_value", $signed(want.query_value), out_query_value);
        check_field("running_total", want.running_total, out_running_total);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("keyed_table_with_clear_all_top regression: fail");
      $finish;
    end
  end

  initial begin
    logic [2:0] op;
    logic [kt_pkg::KEY_W-1:0] key;
    logic [kt_pkg::VAL_W-1:0] val;
    int pick;
    int pool_size;
    int pool_base;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = '0;
    in_key = '0;
    in_value = '0;
    out_ready = 1'b0;
    error_count = 0;
    quiet_cycles = 0;
    idle_mode = IDLE_NONE;
    dir_rows = 0;
    foreach (model_valid[i]) model_valid[i] = 1'b0;
    model_count = '0;
    model_sum = '0;

    add_row(kt_pkg::OP_COUNT, 10'd0, 32'd0, 1'b1, 11'd0, 32'd0, 64'd0);
    add_row(kt_pkg::OP_QUERY, 10'd0, 32'd0, 1'b1, 11'd0, '1, '1);
    add_row(kt_pkg::OP_QUERY, 10'd1023, '1, 1'b1, 11'd0, '1, 64'hFFFF_FFFF_FFFF_FFFE);
    add_row(OP_SPARE_7, 10'd1023, '1, 1'b1, 11'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFE);
    add_row(kt_pkg::OP_CLEAR, 10'd0, 32'd0, 1'b1, 11'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFE);
    add_row(kt_pkg::OP_REMOVE, 10'd1023, 32'd0, 1'b1, 11'd0, 32'd0,
            64'hFFFF_FFFF_FFFF_FFFE);
    add_row(kt_pkg::OP_SET, 10'd0, 32'h7FFF_FFFF, 1'b0, '0, '0, '0);
    add_row(kt_pkg::OP_SET, 10'd1023, 32'h8000_0000, 1'b0, '0, '0, '0);
    add_row(kt_pkg::OP_QUERY, 10'd0, 32'd0, 1'b0, '0, '0, '0);
    add_row(kt_pkg::OP_QUERY, 10'd1023, 32'd0, 1'b0, '0, '0, '0);
    add_row(kt_pkg::OP_SET, 10'd0, '1, 1'b0, '0, '0, '0);
    add_row(kt_pkg::OP_COUNT, 10'd0, 32'd0, 1'b0, '0, '0, '0);
    add_row(kt_pkg::OP_SET, 10'd512, 32'd0, 1'b0, '0, '0, '0);
    add_row(kt_pkg::OP_REMOVE, 10'd0, 32'd0, 1'b0, '0, '0, '0);
    add_row(kt_pkg::OP_REMOVE, 10'd0, 32'd0, 1'b0, '0, '0, '0);
    add_row(kt_pkg::OP_QUERY, 10'd0, 32'd0, 1'b0, '0, '0, '0);
    add_row(kt_pkg::OP_QUERY, 10'd512, 32'd0, 1'b0, '0, '0, '0);
    add_row(OP_SPARE_5, 10'd5, 32'd123, 1'b0, '0, '0, '0);
    add_row(OP_SPARE_6, 10'd5, 32'd0, 1'b0, '0, '0, '0);
    add_row(kt_pkg::OP_CLEAR, 10'd0, 32'd0, 1'b0, '0, '0, '0);
    add_row(kt_pkg::OP_COUNT, 10'd0, 32'd0, 1'b0, '0, '0, '0);
    add_row(kt_pkg::OP_QUERY, 10'd1023, 32'd0, 1'b0, '0, '0, '0);
    add_row(kt_pkg::OP_SET, 10'd1023, 32'd1, 1'b0, '0, '0, '0);
    add_row(kt_pkg::OP_REMOVE, 10'd1023, 32'd0, 1'b0, '0, '0, '0);
    add_row(kt_pkg::OP_COUNT, 10'd0, 32'd0, 1'b0, '0, '0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < dir_rows; r++) begin
      send_cmd(dir_op[r], dir_key[r], dir_val[r], dir_typed[r], dir_want[r]);
    end
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      idle_mode = idle_mode_t'(phase);
      case (phase)
        0: pool_size = 16;
        1: pool_size = 64;
        2: pool_size = 8;
        default: pool_size = 1024;
      endcase
      pool_base = $urandom_range(1023, 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(99, 0);
        if (pick < 30) op = kt_pkg::OP_SET;
        else if (pick < 50) op = kt_pkg::OP_REMOVE;
        else if (pick < 75) op = kt_pkg::OP_QUERY;
        else if (pick < 87) op = kt_pkg::OP_COUNT;
        else if (pick < 91) op = kt_pkg::OP_CLEAR;
        else if (pick < 94) op = OP_SPARE_5;
        else if (pick < 97) op = OP_SPARE_6;
        else op = OP_SPARE_7;
        if ($urandom_range(3, 0) == 0) key = kt_pkg::KEY_W'($urandom);
        else key = kt_pkg::KEY_W'(pool_base + $urandom_range(pool_size - 1, 0));
        case ($urandom_range(9, 0))
          0: val = 32'h7FFF_FFFF;
          1: val = 32'h8000_0000;
          2: val = '1;
          3: val = '0;
          default: val = $urandom;
        endcase
        send_cmd(op, key, val, 1'b0, '0);
      end
      @(negedge clk);
      in_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clk);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("keyed_table_with_clear_all_top regression: pass");
    end else begin
      $display("keyed_table_with_clear_all_top regression: fail");
    end
    $finish;
  end

endmodule
